/* hw/rtl/kwdm_pkg.sv */
// Package for the k-way descending merge block.
// Holds action codes, control structs and reset constants.
// Used by kwdm_cell and k_way_descending_merge_top.
`default_nettype none

package kwdm_pkg;

  localparam int unsigned MaxListsDefault = 16;
  localparam int unsigned ValW            = 31;
  localparam int unsigned CfgW            = 5;
  localparam int unsigned OutListW        = 4;
  localparam logic [CfgW-1:0] NumListsReset = 5'd16;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_REFILL = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef struct packed {
    logic load;
    logic refill;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cell_flag_t;

endpackage

`default_nettype wire

/* hw/rtl/kwdm_cell.sv */
// One position of the ordered head array: a list id and its head value.
// Shifts with its neighbors on load and refill; depends on kwdm_pkg.
`default_nettype none

module kwdm_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdW     = 4,
  parameter int unsigned CntW    = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire kwdm_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [CntW-1:0]             loaded_i,
  input  wire logic [kwdm_pkg::ValW-1:0]   new_val_i,
  input  wire logic [IdW-1:0]              new_id_i,
  input  wire logic [IdW-1:0]              left_id_i,
  input  wire logic [kwdm_pkg::ValW-1:0]   left_val_i,
  input  wire kwdm_pkg::cell_flag_t        left_flag_i,
  input  wire logic [IdW-1:0]              right_id_i,
  input  wire logic [kwdm_pkg::ValW-1:0]   right_val_i,
  input  wire kwdm_pkg::cell_flag_t        right_flag_i,
  output kwdm_pkg::cell_flag_t             flag_o,
  output logic [IdW-1:0]                   id_o,
  output logic [kwdm_pkg::ValW-1:0]        val_o,
  output logic [IdW-1:0]                   id_d_o,
  output logic [kwdm_pkg::ValW-1:0]        val_d_o
);

  logic [IdW-1:0]            id_q, id_d;
  logic [kwdm_pkg::ValW-1:0] val_q, val_d;
  logic                      in_range;
  logic                      at_loaded;

  assign in_range  = CntW'(CellIdx) < loaded_i;
  assign at_loaded = CntW'(CellIdx) == loaded_i;
  assign flag_o.lt = in_range && (val_q < new_val_i);
  assign flag_o.gt = in_range && (new_val_i < val_q);

  always_comb begin
    id_d  = id_q;
    val_d = val_q;
    if (ctrl_i.clear) begin
      id_d  = IdW'(CellIdx);
      val_d = '0;
    end else if (ctrl_i.load) begin
      if (left_flag_i.lt) begin
        id_d  = left_id_i;
        val_d = left_val_i;
      end else if (flag_o.lt || at_loaded) begin
        id_d  = new_id_i;
        val_d = new_val_i;
      end
    end else if (ctrl_i.refill) begin
      if (right_flag_i.gt) begin
        id_d  = right_id_i;
        val_d = right_val_i;
      end else if ((CellIdx == 0) || flag_o.gt) begin
        id_d  = new_id_i;
        val_d = new_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q  <= IdW'(CellIdx);
      val_q <= '0;
    end else begin
      id_q  <= id_d;
      val_q <= val_d;
    end
  end

  assign id_o    = id_q;
  assign val_o   = val_q;
  assign id_d_o  = id_d;
  assign val_d_o = val_d;

endmodule

`default_nettype wire

/* hw/rtl/k_way_descending_merge_top.sv */
// Top level of the k-way descending merge block.
// Instantiates a chain of kwdm_cell; depends on kwdm_pkg.
//
// Usage: feed beats on the input channel (in_valid_i / in_stall_o) carrying
// action_i and value_i. Load beats enter one list head each, in list order,
// into the sorted cell chain. Start and refill beats each produce one result
// beat on the output channel (out_valid_o / out_stall_i): the largest head
// and its list id, or done_res_o when every loaded list is exhausted. Load
// and clear beats produce no result. num_lists is written through cfg_we_i /
// cfg_data_i; the user must do so while the block is idle (not enforced).
// A result reaches the output register in the cycle after its input beat is
// accepted. Throughput: one beat per cycle while in_stall_o is low; all cells
// compare against the incoming value at once and shift one place in that cycle.
// Reset: cells hold ids in identity order with zero heads, nothing loaded,
// num_lists is 16, the output register is empty.
// Stall: while a result waits under out_stall_i, in_stall_o is high and the
// result holds; input is taken again in the cycle the result is taken.
`default_nettype none

module k_way_descending_merge_top #(
  parameter int unsigned MaxLists = kwdm_pkg::MaxListsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [kwdm_pkg::ValW-1:0]     value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [kwdm_pkg::CfgW-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [kwdm_pkg::ValW-1:0]          out_value_o,
  output logic [kwdm_pkg::OutListW-1:0]      out_list_o,
  output logic                               done_res_o
);

  localparam int unsigned IdW  = $clog2(MaxLists);
  localparam int unsigned CntW = $clog2(MaxLists + 1);
  localparam int unsigned VW   = kwdm_pkg::ValW;

  logic [kwdm_pkg::CfgW-1:0] num_lists_q;
  logic [CntW-1:0]           loaded_q, loaded_d;
  logic                      finished_q, finished_d;

  logic                      out_valid_q, out_valid_d;
  logic [VW-1:0]             out_value_q, out_value_d;
  logic [kwdm_pkg::OutListW-1:0] out_list_q, out_list_d;
  logic                      done_q, done_d;

  logic                      accept;
  logic                      emit;
  logic                      load_ok;
  logic                      result_done;
  kwdm_pkg::action_e         action;
  kwdm_pkg::cell_ctrl_t      ctrl;
  logic [IdW-1:0]            new_id;
  logic [31:0]               top_ext;

  kwdm_pkg::cell_flag_t      flag    [MaxLists];
  logic [IdW-1:0]            ids     [MaxLists];
  logic [VW-1:0]             vals    [MaxLists];
  logic [IdW-1:0]            ids_d   [MaxLists];
  logic [VW-1:0]             vals_d  [MaxLists];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign action     = kwdm_pkg::action_e'(action_i);

  assign load_ok = !finished_q
                && (32'(loaded_q) < 32'(num_lists_q))
                && (32'(loaded_q) < 32'(MaxLists));

  always_comb begin
    ctrl   = '0;
    emit   = 1'b0;
    new_id = ids[0];
    case (action)
      kwdm_pkg::ACT_LOAD: begin
        ctrl.load = accept && load_ok;
        new_id    = loaded_q[IdW-1:0];
      end
      kwdm_pkg::ACT_START: begin
        emit = accept;
      end
      kwdm_pkg::ACT_REFILL: begin
        ctrl.refill = accept && !finished_q && (loaded_q != '0);
        emit        = accept;
      end
      kwdm_pkg::ACT_CLEAR: begin
        ctrl.clear = accept;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  for (genvar k = 0; k < MaxLists; k++) begin : g_cell
    logic [IdW-1:0]       l_id, r_id;
    logic [VW-1:0]        l_val, r_val;
    kwdm_pkg::cell_flag_t l_flag, r_flag;

    if (k == 0) begin : g_first
      assign l_id   = '0;
      assign l_val  = '0;
      assign l_flag = '0;
    end else begin : g_mid
      assign l_id   = ids[k-1];
      assign l_val  = vals[k-1];
      assign l_flag = flag[k-1];
    end

    if (k == MaxLists - 1) begin : g_last
      assign r_id   = '0;
      assign r_val  = '0;
      assign r_flag = '0;
    end else begin : g_inner
      assign r_id   = ids[k+1];
      assign r_val  = vals[k+1];
      assign r_flag = flag[k+1];
    end

    kwdm_cell #(
      .CellIdx (k),
      .IdW     (IdW),
      .CntW    (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .loaded_i     (loaded_q),
      .new_val_i    (value_i),
      .new_id_i     (new_id),
      .left_id_i    (l_id),
      .left_val_i   (l_val),
      .left_flag_i  (l_flag),
      .right_id_i   (r_id),
      .right_val_i  (r_val),
      .right_flag_i (r_flag),
      .flag_o       (flag[k]),
      .id_o         (ids[k]),
      .val_o        (vals[k]),
      .id_d_o       (ids_d[k]),
      .val_d_o      (vals_d[k])
    );
  end

  always_comb begin
    loaded_d = loaded_q;
    if (ctrl.clear) begin
      loaded_d = '0;
    end else if (ctrl.load) begin
      loaded_d = loaded_q + CntW'(1);
    end
  end

  assign result_done = (loaded_d == '0) || (vals_d[0] == '0);
  assign top_ext     = 32'(ids_d[0]);

  always_comb begin
    finished_d = finished_q;
    if (ctrl.clear) begin
      finished_d = 1'b0;
    end else if (emit && result_done) begin
      finished_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_list_d  = out_list_q;
    done_d      = done_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (result_done) begin
        out_value_d = '0;
        out_list_d  = '0;
        done_d      = 1'b1;
      end else begin
        out_value_d = vals_d[0];
        out_list_d  = top_ext[kwdm_pkg::OutListW-1:0];
        done_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_lists_q <= kwdm_pkg::NumListsReset;
      loaded_q    <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_lists_q <= cfg_data_i;
      end
      loaded_q    <= loaded_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_list_q  <= out_list_d;
    done_q      <= done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_list_o  = out_list_q;
  assign done_res_o  = done_q;

endmodule

`default_nettype wire

/* tb/tb_k_way_descending_merge_top.sv */
`timescale 1ns / 1ps
// Testbench for k_way_descending_merge_top: directed beats, then random merge runs over
// several num_lists settings. Every result beat is checked against a local merge model.
// Depends on kwdm_pkg and the RTL of the block.

module tb_k_way_descending_merge_top;

  localparam int MaxL = kwdm_pkg::MaxListsDefault;
  localparam int ValW = kwdm_pkg::ValW;
  localparam int CfgW = kwdm_pkg::CfgW;
  localparam int OutListW = kwdm_pkg::OutListW;
  localparam int IdW = 4;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int Phases = 8;
  localparam int PhaseBeats = 205;
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  typedef struct packed {
    logic [MaxL-1:0][ValW-1:0] head;
    logic [MaxL-1:0][IdW-1:0]  order;
    logic [4:0]                loaded;
    logic                      finished;
  } merge_state_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [IdW-1:0]  list;
    logic            done;
  } merge_result_t;

  typedef struct packed {
    kwdm_pkg::action_e act;
    logic [ValW-1:0]   value;
  } merge_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = kwdm_pkg::ACT_LOAD;
  logic [ValW-1:0]     value_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ValW-1:0]     out_value_o;
  logic [OutListW-1:0] out_list_o;
  logic                done_res_o;

  merge_beat_t     beats_to_send[$];
  merge_result_t   merge_expected[$];
  merge_state_t    pred_merge;
  merge_state_t    plan_merge;
  logic [CfgW-1:0] pred_num_lists;
  logic [CfgW-1:0] plan_num_lists;
  int              mismatches = 0;
  int              idle_cycles = 0;
  int              beats_queued = 0;
  bit              beat_taken = 1'b0;
  bit              calm = 1'b0;
  bit              hold_req = 1'b0;
  int              send_pct = 10;
  int              recv_pct = 10;
  int              send_gap = 0;
  int              recv_gap = 0;
  int              hold_left = 0;

  k_way_descending_merge_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_value_o(out_value_o),
    .out_list_o (out_list_o),
    .done_res_o (done_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic merge_state_t merge_cleared();
    merge_state_t s;
    s = '0;
    for (int i = 0; i < MaxL; i++) s.order[i] = IdW'(i);
    return s;
  endfunction

  function automatic merge_result_t merge_emit(inout merge_state_t s);
    merge_result_t r;
    r = '0;
    if (s.loaded == 0 || s.head[s.order[0]] == 0) begin
      s.finished = 1'b1;
      r.done = 1'b1;
    end else begin
      r.value = s.head[s.order[0]];
      r.list = s.order[0];
    end
    return r;
  endfunction

  // Advance the merge state by one beat; returns 1 when the beat yields a result.
  function automatic bit merge_step(inout merge_state_t s, input logic [CfgW-1:0] num_lists,
                                    input kwdm_pkg::action_e act, input logic [ValW-1:0] v,
                                    output merge_result_t r);
    int limit;
    int p;
    int i;
    logic [IdW-1:0] top;
    r = '0;
    limit = (num_lists > MaxL) ? MaxL : int'(num_lists);
    case (act)
      kwdm_pkg::ACT_LOAD: begin
        if (!s.finished && s.loaded < limit) begin
          p = 0;
          while (p < s.loaded && s.head[s.order[p]] >= v) p++;
          for (int k = s.loaded; k > p; k--) s.order[k] = s.order[k-1];
          s.order[p] = s.loaded[IdW-1:0];
          s.head[s.loaded[IdW-1:0]] = v;
          s.loaded = s.loaded + 1'b1;
        end
        return 1'b0;
      end
      kwdm_pkg::ACT_START: begin
        r = merge_emit(s);
        return 1'b1;
      end
      kwdm_pkg::ACT_REFILL: begin
        if (!s.finished && s.loaded > 0) begin
          top = s.order[0];
          s.head[top] = v;
          i = 0;
          while (i + 1 < s.loaded && v < s.head[s.order[i+1]]) i++;
          for (int k = 0; k < i; k++) s.order[k] = s.order[k+1];
          s.order[i] = top;
        end
        r = merge_emit(s);
        return 1'b1;
      end
      default: begin
        s = merge_cleared();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return ValMax;
      1: return ValW'($urandom_range(1, 8));
      default: return ValW'($urandom);
    endcase
  endfunction

  task automatic queue_beat(input kwdm_pkg::action_e act, input logic [ValW-1:0] v,
                            output merge_result_t r);
    merge_beat_t b;
    b.act = act;
    b.value = v;
    beats_to_send.push_back(b);
    beats_queued++;
    void'(merge_step(plan_merge, plan_num_lists, act, v, r));
  endtask

  // One merge run: clear, load n descending lists, start, then refill whichever list
  // was emitted until done (or drop out early).
  task automatic queue_merge(input int n, input bit tight);
    logic [ValW-1:0] tail [MaxL];
    int left [MaxL];
    merge_result_t r;
    logic [ValW-1:0] v;
    int steps;
    queue_beat(kwdm_pkg::ACT_CLEAR, rand_value(), r);
    for (int id = 0; id < n; id++) begin
      left[id] = $urandom_range(0, 4);
      if (left[id] == 0) begin
        v = '0;
      end else if (tight) begin
        v = ValW'($urandom_range(1, 6));
      end else begin
        v = rand_value();
      end
      if (v == 0 && left[id] > 0) v = 1;
      tail[id] = v;
      if (left[id] > 0) left[id]--;
      queue_beat(kwdm_pkg::ACT_LOAD, v, r);
    end
    if ($urandom_range(0, 9) == 0) queue_beat(kwdm_pkg::ACT_REFILL, rand_value(), r);
    queue_beat(kwdm_pkg::ACT_START, ValW'($urandom), r);
    steps = 0;
    while (!r.done && steps < 100) begin
      steps++;
      if ($urandom_range(0, 19) == 0) begin
        queue_beat(kwdm_pkg::ACT_START, ValW'($urandom), r);
      end else if ($urandom_range(0, 39) == 0) begin
        break;
      end else begin
        if (left[r.list] > 0) begin
          v = ValW'($urandom_range(1, tail[r.list]));
          left[r.list]--;
        end else begin
          v = '0;
        end
        tail[r.list] = v;
        queue_beat(kwdm_pkg::ACT_REFILL, v, r);
      end
    end
    if (r.done && $urandom_range(0, 3) == 0) begin
      queue_beat(kwdm_pkg::ACT_LOAD, rand_value(), r);
      queue_beat($urandom_range(0, 1) ? kwdm_pkg::ACT_START : kwdm_pkg::ACT_REFILL,
                 rand_value(), r);
    end
  endtask

  task automatic queue_noise(input int count);
    merge_result_t r;
    for (int k = 0; k < count; k++) begin
      queue_beat(kwdm_pkg::action_e'($urandom_range(0, 3)), rand_value(), r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ValW-1:0] got,
                                 input logic [ValW-1:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_num_lists(input logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    plan_num_lists = v;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (beats_to_send.size() != 0 || in_valid_i || merge_expected.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Input driver: hold a beat until taken, then idle or advance to the next one.
  always @(negedge clk_i) begin
    merge_beat_t b;
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < send_pct) begin
        send_gap = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else if (beats_to_send.size() != 0) begin
        b = beats_to_send.pop_front();
        in_valid_i <= 1'b1;
        action_i <= b.act;
        value_i <= b.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold when requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < recv_pct) begin
        recv_gap = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    merge_result_t got;
    merge_result_t want;
    if (rst_ni) begin
      beat_taken = in_valid_i && !in_stall_o;
      if (beat_taken) begin
        if (merge_step(pred_merge, pred_num_lists, kwdm_pkg::action_e'(action_i), value_i,
                       want))
          merge_expected.push_back(want);
      end
      if (cfg_we_i) pred_num_lists = cfg_data_i;
      if (out_valid_o && !out_stall_i) begin
        got = {out_value_o, out_list_o, done_res_o};
        if (merge_expected.size() == 0) begin
          report_mismatch("result with none expected", got.value, '0);
        end else begin
          want = merge_expected.pop_front();
          if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
          if (got.list !== want.list) begin
            report_mismatch("out_list", ValW'(got.list), ValW'(want.list));
          end
          if (got.done !== want.done) begin
            report_mismatch("done_res", ValW'(got.done), ValW'(want.done));
          end
        end
      end
      if (beat_taken || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [CfgW-1:0] phase_cfg [Phases];
    merge_result_t r;
    int lim;
    phase_cfg = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd5, 5'd16};
    phase_cfg[5] = CfgW'($urandom_range(0, 31));
    pred_merge = merge_cleared();
    plan_merge = merge_cleared();
    pred_num_lists = kwdm_pkg::NumListsReset;
    plan_num_lists = kwdm_pkg::NumListsReset;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < Phases; ph++) begin
      send_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
      recv_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
      calm = (ph == Phases - 1);
      write_num_lists(phase_cfg[ph]);
      if (ph == 0) begin
        queue_beat(kwdm_pkg::ACT_START, '0, r);
        queue_beat(kwdm_pkg::ACT_LOAD, 31'd9, r);
        queue_beat(kwdm_pkg::ACT_REFILL, 31'd4, r);
        queue_beat(kwdm_pkg::ACT_CLEAR, ValMax, r);
        queue_beat(kwdm_pkg::ACT_REFILL, 31'd7, r);
        queue_beat(kwdm_pkg::ACT_CLEAR, '0, r);
        queue_beat(kwdm_pkg::ACT_LOAD, ValMax, r);
        queue_beat(kwdm_pkg::ACT_LOAD, ValMax, r);
        queue_beat(kwdm_pkg::ACT_LOAD, 31'd1, r);
        queue_beat(kwdm_pkg::ACT_LOAD, '0, r);
        queue_beat(kwdm_pkg::ACT_REFILL, 31'd5, r);
        queue_beat(kwdm_pkg::ACT_START, ValMax, r);
        queue_beat(kwdm_pkg::ACT_START, '0, r);
        queue_beat(kwdm_pkg::ACT_REFILL, ValMax, r);
        queue_beat(kwdm_pkg::ACT_REFILL, 31'd2, r);
        repeat (4) queue_beat(kwdm_pkg::ACT_REFILL, '0, r);
        queue_beat(kwdm_pkg::ACT_START, '0, r);
        queue_beat(kwdm_pkg::ACT_CLEAR, '0, r);
      end
      lim = (plan_num_lists > MaxL) ? MaxL : int'(plan_num_lists);
      beats_queued = 0;
      while (beats_queued < PhaseBeats) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_noise($urandom_range(1, 8));
        end else begin
          queue_merge($urandom_range(1, (lim + 2 > MaxL) ? MaxL : lim + 2),
                      $urandom_range(0, 2) == 0);
        end
      end
      if (ph == 2) begin
        @(posedge clk_i);
        hold_req = 1'b1;
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
